/* rtl/core/key_hold_time_tracker_top_defines.svh */
// Assertion macros used by the checker file of the key hold time tracker.
`ifndef KEY_HOLD_TIME_TRACKER_TOP_DEFINES_SVH
`define KEY_HOLD_TIME_TRACKER_TOP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define KHT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define KHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kht_pkg.sv */
// ----------------------------------------------------------------------------
// kht_pkg
// Types, sizes, action codes and controller/datapath links for the tracker.
// ----------------------------------------------------------------------------
package kht_pkg;

    localparam int KEY_COUNT = 256;
    localparam int TIME_BITS = 32;

    localparam int KEY_W       = 8;
    localparam int DELTA_W     = 16;
    localparam int THR_W       = 32;
    localparam int OUT_TIME_W  = 32;
    localparam int OUT_COUNT_W = 9;
    localparam int ACTION_W    = 3;

    localparam int AW     = $clog2(KEY_COUNT);
    localparam int CNT_W  = $clog2(KEY_COUNT + 1);
    localparam int KCMP_W = (AW + 1 > KEY_W) ? AW + 1 : KEY_W;
    localparam int SUM_W  = ((TIME_BITS > DELTA_W) ? TIME_BITS : DELTA_W) + 1;
    localparam int WIDE_W = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;
    // Table entry: down flag, held time, released time.
    localparam int WORD_W = 2 * TIME_BITS + 1;

    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [SUM_W-1:0]       t_sum;
    typedef logic [WIDE_W-1:0]      t_wide;
    typedef logic [OUT_TIME_W-1:0]  t_out_time;
    typedef logic [AW-1:0]          t_addr;
    typedef logic [CNT_W-1:0]       t_cnt;
    typedef logic [KCMP_W-1:0]      t_kcmp;
    typedef logic [WORD_W-1:0]      t_word;
    typedef logic [OUT_COUNT_W-1:0] t_out_cnt;

    localparam t_time     TIME_MAX     = '1;
    localparam t_out_time OUT_TIME_MAX = '1;
    localparam t_addr     ADDR_LAST    = t_addr'(KEY_COUNT - 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_PRESS   = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_TICK    = 3'd2,
        ACT_REL_ALL = 3'd3,
        ACT_QUERY   = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_DRAIN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic apply;
        logic sweep_rd;
        logic result;
    } t_dp_cmd;

    typedef struct packed {
        logic is_sweep;
        logic sweep_last;
    } t_dp_status;

endpackage

/* rtl/core/key_hold_time_tracker_top.sv */
// ----------------------------------------------------------------------------
// key_hold_time_tracker_top
// Per-key down flag, held time and released time with one result per item.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge with start high and busy low. Every item
// gives exactly one result, shown for one cycle with o_result_strobe high; the
// receiver cannot stall, so sample it on that cycle. After reset the block
// clears its key table in RAM, one entry a cycle, and holds busy high until
// the whole table is clear. Press, release and query pass through the execute
// and result states before the next possible accept, the strobe showing in
// the cycle the block is ready again. A time tick and release all keys walk
// the whole table, one entry read and one written back each cycle, through
// the execute, sweep, drain and result states. Write input_enable on the
// config channel only while busy is low.
// ----------------------------------------------------------------------------
module key_hold_time_tracker_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // command channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic [kht_pkg::ACTION_W-1:0]         i_action,
    input  logic [kht_pkg::KEY_W-1:0]            i_key,
    input  logic [kht_pkg::DELTA_W-1:0]          i_delta,
    input  logic [kht_pkg::THR_W-1:0]            i_threshold,
    // config channel (input_enable)
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic                                 i_cfg_data,
    // result channel
    output logic                                 o_result_strobe,
    output logic                                 o_key_is_down,
    output logic [kht_pkg::OUT_TIME_W-1:0]       o_down_duration,
    output logic [kht_pkg::OUT_TIME_W-1:0]       o_up_duration,
    output logic                                 o_just_pressed,
    output logic                                 o_just_released,
    output logic                                 o_any_key_down,
    output logic [kht_pkg::OUT_COUNT_W-1:0]      o_keys_down_count
);

    kht_pkg::t_dp_cmd    w_cmd;
    kht_pkg::t_dp_status w_status;
    logic                w_cfg_we;

    // Take a config beat when both sides agree.
    assign w_cfg_we = i_cfg_valid & o_cfg_ready;

    // Clear the table after reset, then sequence each item: accept, apply or sweep, capture the key, report.
    kht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_busy      (busy),
        .o_cfg_ready (o_cfg_ready)
    );

    // Hold per-key state, do the tick arithmetic and register the result beat.
    kht_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_cfg_we          (w_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_key             (i_key),
        .i_delta           (i_delta),
        .i_threshold       (i_threshold),
        .o_result_strobe   (o_result_strobe),
        .o_key_is_down     (o_key_is_down),
        .o_down_duration   (o_down_duration),
        .o_up_duration     (o_up_duration),
        .o_just_pressed    (o_just_pressed),
        .o_just_released   (o_just_released),
        .o_any_key_down    (o_any_key_down),
        .o_keys_down_count (o_keys_down_count)
    );

endmodule

/* rtl/core/kht_ram.sv */
// ----------------------------------------------------------------------------
// kht_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/kht_ctrl.sv */
// ----------------------------------------------------------------------------
// kht_ctrl
// Sequencer: clear the table, accept, apply or sweep the table, report.
// ----------------------------------------------------------------------------
module kht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  kht_pkg::t_dp_status i_status,
    output kht_pkg::t_dp_cmd    o_cmd,
    output logic                o_busy,
    output logic                o_cfg_ready
);

    kht_pkg::t_state r_state;
    kht_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kht_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            kht_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = kht_pkg::S_IDLE;
                end
            end
            kht_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = kht_pkg::S_EXEC;
                end
            end
            kht_pkg::S_EXEC: begin
                if (i_status.is_sweep) begin
                    n_state = kht_pkg::S_SWEEP;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = kht_pkg::S_RESULT;
                end
            end
            kht_pkg::S_SWEEP: begin
                o_cmd.sweep_rd = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = kht_pkg::S_DRAIN;
                end
            end
            kht_pkg::S_DRAIN: begin
                n_state = kht_pkg::S_RESULT;
            end
            kht_pkg::S_RESULT: begin
                o_cmd.result = 1'b1;
                n_state      = kht_pkg::S_IDLE;
            end
            default: begin
                n_state = kht_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != kht_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == kht_pkg::S_IDLE);

endmodule

/* rtl/core/kht_datapath.sv */
// ----------------------------------------------------------------------------
// kht_datapath
// Key table RAM, down count, entry update, table sweep write-back, result.
// ----------------------------------------------------------------------------
module kht_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  kht_pkg::t_dp_cmd                     i_cmd,
    output kht_pkg::t_dp_status                  o_status,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_data,
    input  logic [kht_pkg::ACTION_W-1:0]         i_action,
    input  logic [kht_pkg::KEY_W-1:0]            i_key,
    input  logic [kht_pkg::DELTA_W-1:0]          i_delta,
    input  logic [kht_pkg::THR_W-1:0]            i_threshold,
    output logic                                 o_result_strobe,
    output logic                                 o_key_is_down,
    output logic [kht_pkg::OUT_TIME_W-1:0]       o_down_duration,
    output logic [kht_pkg::OUT_TIME_W-1:0]       o_up_duration,
    output logic                                 o_just_pressed,
    output logic                                 o_just_released,
    output logic                                 o_any_key_down,
    output logic [kht_pkg::OUT_COUNT_W-1:0]      o_keys_down_count
);

    function automatic kht_pkg::t_time sat_add(kht_pkg::t_time t,
                                               logic [kht_pkg::DELTA_W-1:0] d);
        kht_pkg::t_sum s;
        s = kht_pkg::t_sum'(t) + kht_pkg::t_sum'(d);
        if (s > kht_pkg::t_sum'(kht_pkg::TIME_MAX)) begin
            return kht_pkg::TIME_MAX;
        end
        return kht_pkg::t_time'(s);
    endfunction

    function automatic kht_pkg::t_out_time clip_out(kht_pkg::t_time t);
        kht_pkg::t_wide w;
        w = kht_pkg::t_wide'(t);
        if (w > kht_pkg::t_wide'(kht_pkg::OUT_TIME_MAX)) begin
            return kht_pkg::OUT_TIME_MAX;
        end
        return kht_pkg::t_out_time'(w);
    endfunction

    // Latched item
    logic [kht_pkg::ACTION_W-1:0] r_action;
    logic [kht_pkg::KEY_W-1:0]    r_key;
    logic [kht_pkg::DELTA_W-1:0]  r_delta;
    logic [kht_pkg::THR_W-1:0]    r_threshold;
    logic                         r_input_enable;

    // Down count and the named key's entry after its item
    kht_pkg::t_cnt                r_down_total;
    logic                         r_cur_down;
    kht_pkg::t_time               r_cur_held;
    kht_pkg::t_time               r_cur_rel;

    // Sweep
    kht_pkg::t_addr r_idx;
    logic           r_wr_pend;
    kht_pkg::t_addr r_wr_addr;

    // Result
    logic                      r_strobe;
    logic                      r_out_down;
    kht_pkg::t_out_time        r_out_held;
    kht_pkg::t_out_time        r_out_rel;
    logic                      r_out_jp;
    logic                      r_out_jr;
    logic                      r_out_any;
    kht_pkg::t_out_cnt         r_out_cnt;

    kht_pkg::t_addr w_kidx;
    logic           w_key_ok;
    logic           w_event_ok;
    logic           w_is_rel_all;
    kht_pkg::t_addr w_raddr;
    logic           w_we;
    kht_pkg::t_addr w_waddr;
    kht_pkg::t_word w_wdata;
    kht_pkg::t_word w_rdata;
    logic           w_rd_down;
    kht_pkg::t_time w_rd_held;
    kht_pkg::t_time w_rd_rel;
    logic           w_new_down;
    kht_pkg::t_time w_new_held;
    kht_pkg::t_time w_new_rel;
    logic           w_wb_down;
    kht_pkg::t_time w_wb_held;
    kht_pkg::t_time w_wb_rel;
    kht_pkg::t_time w_res_held;
    kht_pkg::t_time w_res_rel;

    assign w_kidx       = kht_pkg::t_addr'(r_key);
    assign w_key_ok     = kht_pkg::t_kcmp'(r_key) < kht_pkg::t_kcmp'(kht_pkg::KEY_COUNT);
    assign w_event_ok   = r_input_enable && w_key_ok;
    assign w_is_rel_all = (r_action == kht_pkg::ACT_REL_ALL);

    always_comb begin
        if (i_cmd.sweep_rd) begin
            w_raddr = r_idx;
        end else if (i_cmd.load) begin
            w_raddr = kht_pkg::t_addr'(i_key);
        end else begin
            w_raddr = w_kidx;
        end
    end

    assign w_rd_down = w_rdata[kht_pkg::WORD_W-1];
    assign w_rd_held = w_rdata[kht_pkg::WORD_W-2:kht_pkg::TIME_BITS];
    assign w_rd_rel  = w_rdata[kht_pkg::TIME_BITS-1:0];

    // Press or release of the entry read at accept
    always_comb begin
        w_new_down = w_rd_down;
        w_new_held = w_rd_held;
        w_new_rel  = w_rd_rel;
        if (w_event_ok) begin
            case (r_action)
                kht_pkg::ACT_PRESS: begin
                    w_new_down = 1'b1;
                    w_new_rel  = '0;
                end
                kht_pkg::ACT_RELEASE: begin
                    w_new_down = 1'b0;
                    w_new_held = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Sweep write-back of the entry read in the previous cycle
    always_comb begin
        w_wb_down = w_rd_down;
        w_wb_held = w_rd_held;
        w_wb_rel  = w_rd_rel;
        if (w_is_rel_all) begin
            w_wb_down = 1'b0;
            w_wb_held = '0;
        end else if (w_rd_down) begin
            w_wb_held = sat_add(w_rd_held, r_delta);
        end else begin
            w_wb_rel = sat_add(w_rd_rel, r_delta);
        end
    end

    // One write port: clearing pass, sweep write-back or entry update
    always_comb begin
        if (i_cmd.clear) begin
            w_we    = 1'b1;
            w_waddr = r_idx;
            w_wdata = '0;
        end else if (r_wr_pend) begin
            w_we    = 1'b1;
            w_waddr = r_wr_addr;
            w_wdata = {w_wb_down, w_wb_held, w_wb_rel};
        end else begin
            w_we    = i_cmd.apply;
            w_waddr = w_kidx;
            w_wdata = {w_new_down, w_new_held, w_new_rel};
        end
    end

    kht_ram #(
        .WIDTH (kht_pkg::WORD_W),
        .DEPTH (kht_pkg::KEY_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= i_action;
            r_key       <= i_key;
            r_delta     <= i_delta;
            r_threshold <= i_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_input_enable <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_wr_pend <= 1'b0;
            r_wr_addr <= '0;
        end else begin
            r_wr_pend <= i_cmd.sweep_rd;
            r_wr_addr <= r_idx;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.sweep_rd || i_cmd.clear) begin
                r_idx <= r_idx + kht_pkg::t_addr'(1);
            end
        end
    end

    // Count only real up/down transitions; release all drops the count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_total <= '0;
        end else if (i_cmd.apply && w_event_ok) begin
            if (r_action == kht_pkg::ACT_PRESS && !w_rd_down) begin
                r_down_total <= r_down_total + kht_pkg::t_cnt'(1);
            end else if (r_action == kht_pkg::ACT_RELEASE && w_rd_down &&
                         r_down_total != '0) begin
                r_down_total <= r_down_total - kht_pkg::t_cnt'(1);
            end
        end else if (i_cmd.sweep_rd && w_is_rel_all) begin
            r_down_total <= '0;
        end
    end

    // Hold the named key's entry as it is written back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_cur_down <= w_new_down;
            r_cur_held <= w_new_held;
            r_cur_rel  <= w_new_rel;
        end else if (r_wr_pend && r_wr_addr == w_kidx) begin
            r_cur_down <= w_wb_down;
            r_cur_held <= w_wb_held;
            r_cur_rel  <= w_wb_rel;
        end
    end

    assign w_res_held = w_key_ok ? r_cur_held : '0;
    assign w_res_rel  = w_key_ok ? r_cur_rel  : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            r_out_down <= w_key_ok & r_cur_down;
            r_out_held <= clip_out(w_res_held);
            r_out_rel  <= clip_out(w_res_rel);
            r_out_jp   <= kht_pkg::t_wide'(w_res_held) <= kht_pkg::t_wide'(r_threshold);
            r_out_jr   <= kht_pkg::t_wide'(w_res_rel) <= kht_pkg::t_wide'(r_threshold);
            r_out_any  <= (r_down_total != '0);
            r_out_cnt  <= kht_pkg::t_out_cnt'(r_down_total);
        end
    end

    assign o_status.is_sweep   = (r_action == kht_pkg::ACT_TICK) || w_is_rel_all;
    assign o_status.sweep_last = (r_idx == kht_pkg::ADDR_LAST);

    assign o_result_strobe   = r_strobe;
    assign o_key_is_down     = r_out_down;
    assign o_down_duration   = r_out_held;
    assign o_up_duration     = r_out_rel;
    assign o_just_pressed    = r_out_jp;
    assign o_just_released   = r_out_jr;
    assign o_any_key_down    = r_out_any;
    assign o_keys_down_count = r_out_cnt;

endmodule

/* rtl/core/kht_checker.sv */
// ----------------------------------------------------------------------------
// kht_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_hold_time_tracker_top_defines.svh"

module kht_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic [kht_pkg::ACTION_W-1:0]         i_action,
    input logic [kht_pkg::KEY_W-1:0]            i_key,
    input logic [kht_pkg::DELTA_W-1:0]          i_delta,
    input logic [kht_pkg::THR_W-1:0]            i_threshold,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready,
    input logic                                 i_cfg_data,
    input logic                                 o_result_strobe,
    input logic                                 o_key_is_down,
    input logic [kht_pkg::OUT_TIME_W-1:0]       o_down_duration,
    input logic [kht_pkg::OUT_TIME_W-1:0]       o_up_duration,
    input logic                                 o_just_pressed,
    input logic                                 o_just_released,
    input logic                                 o_any_key_down,
    input logic [kht_pkg::OUT_COUNT_W-1:0]      o_keys_down_count
);

    // An accepted item makes the block busy.
    `KHT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, start && !busy, busy, "no busy after accept")

    // A result beat closes the item: the block is free, and was busy just before.
    `KHT_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_result_strobe, !busy && $past(busy), "strobe out of sequence")

    // A zero held time is always within any threshold.
    `KHT_ASSERT_SAME(a_zero_held, i_clk, i_rst_n, o_result_strobe && o_down_duration == 32'd0, o_just_pressed, "zero held time not flagged")

    // A key reported down means the down count is nonzero.
    `KHT_ASSERT_SAME(a_down_count, i_clk, i_rst_n, o_result_strobe && o_key_is_down, o_any_key_down, "down key with zero count")

endmodule

bind key_hold_time_tracker_top kht_checker u_kht_checker (.*);
